>>> hdl/wbmm_pkg.sv
// package for the windowed block min/max monitor
// holds sizes, action codes, state type and register clamp functions
// used by windowed_block_min_max
`default_nettype none

package wbmm_pkg;

    // sizes
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_BLOCKS   = 16;
    localparam int MAX_SAMPLES  = 4096;
    localparam int SAMPLE_BITS  = 24;

    localparam int CH_W     = $clog2(MAX_CHANNELS);        // channel index
    localparam int CHCNT_W  = $clog2(MAX_CHANNELS + 1);    // channel count
    localparam int SLOT_W   = $clog2(MAX_BLOCKS);          // ring slot index
    localparam int BLKCNT_W = $clog2(MAX_BLOCKS + 1);      // block count
    localparam int SPOS_W   = $clog2(MAX_SAMPLES);         // sample position
    localparam int SCNT_W   = $clog2(MAX_SAMPLES + 1);     // sample count
    localparam int ADDR_W   = SLOT_W + CH_W;
    localparam int TBL_DEPTH = MAX_BLOCKS * MAX_CHANNELS;

    // register field widths
    localparam int CFG_CH_W   = 7;
    localparam int CFG_SMP_W  = 13;
    localparam int CFG_SHOW_W = 5;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_SHOWN      = 2'd2;

    // action codes
    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_QCHAN   = 2'd1;
    localparam logic [1:0] ACT_QGLOBAL = 2'd2;

    // value sentinels
    localparam logic signed [SAMPLE_BITS-1:0] VAL_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] VAL_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUSH  = 7'b0000010,
        S_ROW   = 7'b0000100,
        S_QSET  = 7'b0001000,
        S_QRUN  = 7'b0010000,
        S_QWAIT = 7'b0100000,
        S_QOUT  = 7'b1000000
    } t_state;

    // effective register values: zero acts as one, large values saturate
    function automatic logic [CFG_CH_W-1:0] f_eff_channels(input logic [CFG_CH_W-1:0] v);
        logic [CFG_CH_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_CH_W'(1);
        else if (v > CFG_CH_W'(MAX_CHANNELS)) r = CFG_CH_W'(MAX_CHANNELS);
        return r;
    endfunction

    function automatic logic [CFG_SMP_W-1:0] f_eff_samples(input logic [CFG_SMP_W-1:0] v);
        logic [CFG_SMP_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_SMP_W'(1);
        else if (v > CFG_SMP_W'(MAX_SAMPLES)) r = CFG_SMP_W'(MAX_SAMPLES);
        return r;
    endfunction

    function automatic logic [CFG_SHOW_W-1:0] f_eff_shown(input logic [CFG_SHOW_W-1:0] v);
        logic [CFG_SHOW_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_SHOW_W'(1);
        else if (v > CFG_SHOW_W'(MAX_BLOCKS)) r = CFG_SHOW_W'(MAX_BLOCKS);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/wbmm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module wbmm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/windowed_block_min_max.sv
// top level of the windowed block min/max monitor
// depends on wbmm_pkg and wbmm_ram
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_action, i_sample, i_channel
//  output    out        o_out_valid / i_out_ready  o_is_query ... o_block_done
//  config    in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// a push is accepted, then makes one pass through the shared compare pair;
// a push that ends a channel row then writes the slot ram in S_ROW once the output register is free.
// a query walks blocks * channels ram entries, reading one ram entry per cycle,
// and merges the last read in S_QWAIT; an empty window skips the walk.
// reset is synchronous, active low; the slot ram is not cleared.
// a result waiting in the output register stalls the sequencer only when the
// next result is ready; the input side stays open until then.
`default_nettype none

module windowed_block_min_max
    import wbmm_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input transactions
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_action,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [CH_W-1:0]               i_channel,
    // output transactions
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_is_query,
    output logic [CH_W-1:0]                    o_row_channel,
    output logic signed [SAMPLE_BITS-1:0]      o_row_min,
    output logic signed [SAMPLE_BITS-1:0]      o_row_max,
    output logic signed [SAMPLE_BITS-1:0]      o_window_min,
    output logic signed [SAMPLE_BITS-1:0]      o_window_max,
    output logic                               o_window_empty,
    output logic signed [SAMPLE_BITS-1:0]      o_ever_min,
    output logic signed [SAMPLE_BITS-1:0]      o_ever_max,
    output logic                               o_block_done,
    // configuration writes
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // control state
    t_state                  r_state, n_state;
    logic [CFG_CH_W-1:0]     r_cfg_channels;
    logic [CFG_SMP_W-1:0]    r_cfg_samples;
    logic [CFG_SHOW_W-1:0]   r_cfg_shown;
    logic [SPOS_W-1:0]       r_spos;
    logic [CH_W-1:0]         r_cpos;
    logic [SLOT_W-1:0]       r_wslot;
    logic [BLKCNT_W-1:0]     r_filled;
    logic                    r_out_valid;
    logic                    r_rd_vld;
    logic signed [SAMPLE_BITS-1:0] r_run_min, r_run_max;
    logic signed [SAMPLE_BITS-1:0] r_ever_min, r_ever_max;

    // payload state
    logic [1:0]                    r_act;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic [CH_W-1:0]               r_ich;
    logic signed [SAMPLE_BITS-1:0] r_win_min, r_win_max;
    logic [BLKCNT_W-1:0]           r_qleft;
    logic [SLOT_W-1:0]             r_qslot;
    logic [CH_W-1:0]               r_qch, r_qch_lo;
    logic [CHCNT_W-1:0]            r_qch_hi;
    logic                          r_qempty;

    // output register
    logic                          r_o_is_query;
    logic [CH_W-1:0]               r_o_row_channel;
    logic signed [SAMPLE_BITS-1:0] r_o_row_min, r_o_row_max;
    logic signed [SAMPLE_BITS-1:0] r_o_win_min, r_o_win_max;
    logic                          r_o_win_empty;
    logic signed [SAMPLE_BITS-1:0] r_o_ever_min, r_o_ever_max;
    logic                          r_o_block_done;

    // effective register values
    logic [CFG_CH_W-1:0]   eff_ch;
    logic [CFG_SMP_W-1:0]  eff_smp;
    logic [CFG_SHOW_W-1:0] eff_show;
    logic [CFG_SHOW_W-1:0] new_show;

    assign eff_ch   = f_eff_channels(r_cfg_channels);
    assign eff_smp  = f_eff_samples(r_cfg_samples);
    assign eff_show = f_eff_shown(r_cfg_shown);
    assign new_show = f_eff_shown(i_cfg_data[CFG_SHOW_W-1:0]);

    // handshake
    logic accept, out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // slot ram: min in the upper half, max in the lower half
    logic                         ram_wr, ram_rd;
    logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
    logic [2*SAMPLE_BITS-1:0]     ram_rdata;
    logic signed [SAMPLE_BITS-1:0] ram_min, ram_max;

    assign ram_wr    = (r_state == S_ROW) && out_free;
    assign ram_waddr = {r_wslot, r_cpos};
    assign ram_rd    = (r_state == S_QRUN);
    assign ram_raddr = {r_qslot, r_qch};
    assign ram_min   = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign ram_max   = ram_rdata[SAMPLE_BITS-1:0];

    wbmm_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (ram_waddr),
        .i_wr_data ({r_run_min, r_run_max}),
        .i_rd_en   (ram_rd),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // shared compare pair, operands chosen by state
    logic signed [SAMPLE_BITS-1:0] acc_min, acc_max, cand_min, cand_max;
    logic signed [SAMPLE_BITS-1:0] cmp_min, cmp_max;

    always_comb begin
        acc_min  = r_win_min;
        acc_max  = r_win_max;
        cand_min = ram_min;
        cand_max = ram_max;
        case (r_state)
            S_PUSH: begin
                acc_min  = r_run_min;
                acc_max  = r_run_max;
                cand_min = r_smp;
                cand_max = r_smp;
            end
            S_ROW: begin
                acc_min  = r_ever_min;
                acc_max  = r_ever_max;
                cand_min = r_run_min;
                cand_max = r_run_max;
            end
            default: begin
                acc_min  = r_win_min;
                acc_max  = r_win_max;
                cand_min = ram_min;
                cand_max = ram_max;
            end
        endcase
    end

    assign cmp_min = (cand_min < acc_min) ? cand_min : acc_min;
    assign cmp_max = (cand_max > acc_max) ? cand_max : acc_max;

    // row end and block end detection
    logic [SCNT_W-1:0]  spos_inc;
    logic [CHCNT_W-1:0] cpos_inc;
    logic               row_end, blk_end;

    assign spos_inc = SCNT_W'(r_spos) + SCNT_W'(1);
    assign row_end  = (SCNT_W'(spos_inc) >= SCNT_W'(eff_smp));
    assign cpos_inc = CHCNT_W'(r_cpos) + CHCNT_W'(1);
    assign blk_end  = (cpos_inc >= CHCNT_W'(eff_ch));

    // query window setup
    logic [BLKCNT_W-1:0] q_n;
    logic [CH_W-1:0]     q_lo;
    logic [CHCNT_W-1:0]  q_hi;

    always_comb begin
        q_n = (r_filled > BLKCNT_W'(eff_show)) ? BLKCNT_W'(eff_show) : r_filled;
        if (r_cpos != '0 && q_n > BLKCNT_W'(MAX_BLOCKS - 1)) begin
            q_n = BLKCNT_W'(MAX_BLOCKS - 1);
        end
        if (r_act == ACT_QCHAN) begin
            q_lo = r_ich;
            q_hi = CHCNT_W'(r_ich) + CHCNT_W'(1);
            if (CHCNT_W'(r_ich) >= CHCNT_W'(eff_ch)) q_n = '0;
        end else begin
            q_lo = '0;
            q_hi = CHCNT_W'(eff_ch);
        end
    end

    // walk position
    logic ch_last, blk_last;
    assign ch_last  = ((CHCNT_W'(r_qch) + CHCNT_W'(1)) >= r_qch_hi);
    assign blk_last = (r_qleft == BLKCNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_PUSH:    n_state = S_PUSH;
                        ACT_QCHAN:   n_state = S_QSET;
                        ACT_QGLOBAL: n_state = S_QSET;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH:  n_state = row_end ? S_ROW : S_IDLE;
            S_ROW:   n_state = out_free ? S_IDLE : S_ROW;
            S_QSET:  n_state = (q_n == '0) ? S_QOUT : S_QRUN;
            S_QRUN:  n_state = (ch_last && blk_last) ? S_QWAIT : S_QRUN;
            S_QWAIT: n_state = S_QOUT;
            S_QOUT:  n_state = out_free ? S_IDLE : S_QOUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_channels <= CFG_CH_W'(8);
            r_cfg_samples  <= CFG_SMP_W'(32);
            r_cfg_shown    <= CFG_SHOW_W'(2);
            r_spos         <= '0;
            r_cpos         <= '0;
            r_wslot        <= '0;
            r_filled       <= '0;
            r_out_valid    <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_run_min      <= VAL_TOP;
            r_run_max      <= VAL_BOTTOM;
            r_ever_min     <= VAL_TOP;
            r_ever_max     <= VAL_BOTTOM;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_QRUN);

            // output valid
            if (((r_state == S_ROW) || (r_state == S_QOUT)) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // running extremes and row end
            if (r_state == S_PUSH) begin
                r_run_min <= cmp_min;
                r_run_max <= cmp_max;
                if (!row_end) r_spos <= SPOS_W'(spos_inc);
            end
            if (r_state == S_ROW && out_free) begin
                r_ever_min <= cmp_min;
                r_ever_max <= cmp_max;
                r_run_min  <= VAL_TOP;
                r_run_max  <= VAL_BOTTOM;
                r_spos     <= '0;
                if (blk_end) begin
                    r_cpos  <= '0;
                    r_wslot <= r_wslot + SLOT_W'(1);
                    if (r_filled < BLKCNT_W'(eff_show)) r_filled <= r_filled + BLKCNT_W'(1);
                end else begin
                    r_cpos <= r_cpos + CH_W'(1);
                end
            end

            // configuration writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_CHANNEL_COUNT, REG_SAMPLES_PER_BLOCK: begin
                        if (i_cfg_index == REG_CHANNEL_COUNT) begin
                            r_cfg_channels <= i_cfg_data[CFG_CH_W-1:0];
                        end else begin
                            r_cfg_samples <= i_cfg_data[CFG_SMP_W-1:0];
                        end
                        r_spos    <= '0;
                        r_cpos    <= '0;
                        r_wslot   <= '0;
                        r_filled  <= '0;
                        r_run_min <= VAL_TOP;
                        r_run_max <= VAL_BOTTOM;
                    end
                    REG_BLOCKS_SHOWN: begin
                        r_cfg_shown <= i_cfg_data[CFG_SHOW_W-1:0];
                        if (r_filled > BLKCNT_W'(new_show)) r_filled <= BLKCNT_W'(new_show);
                    end
                    default: ;
                endcase
            end
        end
    end

    // item capture, window walk and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_smp <= i_sample;
            r_ich <= i_channel;
        end

        // merge one ram entry per cycle into the window extremes
        if (r_state == S_QSET) begin
            r_win_min <= VAL_TOP;
            r_win_max <= VAL_BOTTOM;
            r_qleft   <= q_n;
            r_qslot   <= r_wslot - SLOT_W'(1);
            r_qch     <= q_lo;
            r_qch_lo  <= q_lo;
            r_qch_hi  <= q_hi;
            r_qempty  <= (q_n == '0);
        end else if (r_rd_vld) begin
            r_win_min <= cmp_min;
            r_win_max <= cmp_max;
        end

        // walk channels inside a slot, then step to the next older slot
        if (r_state == S_QRUN) begin
            if (ch_last) begin
                r_qch   <= r_qch_lo;
                r_qslot <= r_qslot - SLOT_W'(1);
                r_qleft <= r_qleft - BLKCNT_W'(1);
            end else begin
                r_qch <= r_qch + CH_W'(1);
            end
        end

        // row report
        if (r_state == S_ROW && out_free) begin
            r_o_is_query    <= 1'b0;
            r_o_row_channel <= r_cpos;
            r_o_row_min     <= r_run_min;
            r_o_row_max     <= r_run_max;
            r_o_win_min     <= '0;
            r_o_win_max     <= '0;
            r_o_win_empty   <= 1'b0;
            r_o_ever_min    <= cmp_min;
            r_o_ever_max    <= cmp_max;
            r_o_block_done  <= blk_end;
        end

        // query answer
        if (r_state == S_QOUT && out_free) begin
            r_o_is_query    <= 1'b1;
            r_o_row_channel <= (r_act == ACT_QCHAN) ? r_ich : '0;
            r_o_row_min     <= '0;
            r_o_row_max     <= '0;
            r_o_win_min     <= r_win_min;
            r_o_win_max     <= r_win_max;
            r_o_win_empty   <= r_qempty;
            r_o_ever_min    <= r_ever_min;
            r_o_ever_max    <= r_ever_max;
            r_o_block_done  <= 1'b0;
        end
    end

    // outputs
    assign o_out_valid    = r_out_valid;
    assign o_is_query     = r_o_is_query;
    assign o_row_channel  = r_o_row_channel;
    assign o_row_min      = r_o_row_min;
    assign o_row_max      = r_o_row_max;
    assign o_window_min   = r_o_win_min;
    assign o_window_max   = r_o_win_max;
    assign o_window_empty = r_o_win_empty;
    assign o_ever_min     = r_o_ever_min;
    assign o_ever_max     = r_o_ever_max;
    assign o_block_done   = r_o_block_done;

endmodule

`default_nettype wire
